FILE: rtl/sc1asc_pkg.sv
// ----------------------------------------------------------------------------
// sc1asc_pkg
// Shared types, scan codes and the US layout key tables for the set 1 decoder.
// ----------------------------------------------------------------------------
package sc1asc_pkg;

	localparam logic [7:0] SC_PREFIX     = 8'hE0;
	localparam logic [7:0] SC_RELEASE    = 8'h80;
	localparam logic [6:0] SC_ESC        = 7'h01;
	localparam logic [6:0] SC_CTRL       = 7'h1D;
	localparam logic [6:0] SC_LSHIFT     = 7'h2A;
	localparam logic [6:0] SC_RSHIFT     = 7'h36;
	localparam logic [6:0] NUM_MAIN_KEYS = 7'h3A;
	localparam logic [6:0] ASCII_ESC     = 7'h1B;
	localparam logic [6:0] ASCII_CASE    = 7'h20;
	localparam logic [6:0] ASCII_CTRL    = 7'h40;
	localparam logic [6:0] ASCII_CTRL_HI = 7'h5F;

	typedef struct packed {
		logic prefix;
		logic ctrl;
		logic shift;
	} flags_t;

	typedef struct packed {
		logic       emit;
		logic [6:0] chr;
		flags_t     flags;
	} dec_t;

	function automatic logic [6:0] plain_char(input logic [5:0] code);
		logic [6:0] c;
		begin
			case (code)
				6'h02: c = 7'h31;
				6'h03: c = 7'h32;
				6'h04: c = 7'h33;
				6'h05: c = 7'h34;
				6'h06: c = 7'h35;
				6'h07: c = 7'h36;
				6'h08: c = 7'h37;
				6'h09: c = 7'h38;
				6'h0A: c = 7'h39;
				6'h0B: c = 7'h30;
				6'h0C: c = 7'h2D;
				6'h0D: c = 7'h3D;
				6'h0E: c = 7'h08;
				6'h0F: c = 7'h09;
				6'h10: c = 7'h71;
				6'h11: c = 7'h77;
				6'h12: c = 7'h65;
				6'h13: c = 7'h72;
				6'h14: c = 7'h74;
				6'h15: c = 7'h79;
				6'h16: c = 7'h75;
				6'h17: c = 7'h69;
				6'h18: c = 7'h6F;
				6'h19: c = 7'h70;
				6'h1A: c = 7'h5B;
				6'h1B: c = 7'h5D;
				6'h1C: c = 7'h0A;
				6'h1E: c = 7'h61;
				6'h1F: c = 7'h73;
				6'h20: c = 7'h64;
				6'h21: c = 7'h66;
				6'h22: c = 7'h67;
				6'h23: c = 7'h68;
				6'h24: c = 7'h6A;
				6'h25: c = 7'h6B;
				6'h26: c = 7'h6C;
				6'h27: c = 7'h3B;
				6'h28: c = 7'h27;
				6'h29: c = 7'h60;
				6'h2B: c = 7'h5C;
				6'h2C: c = 7'h7A;
				6'h2D: c = 7'h78;
				6'h2E: c = 7'h63;
				6'h2F: c = 7'h76;
				6'h30: c = 7'h62;
				6'h31: c = 7'h6E;
				6'h32: c = 7'h6D;
				6'h33: c = 7'h2C;
				6'h34: c = 7'h2E;
				6'h35: c = 7'h2F;
				6'h37: c = 7'h2A;
				6'h39: c = 7'h20;
				default: c = 7'h00;
			endcase
			return c;
		end
	endfunction

	function automatic logic [6:0] shift_char(input logic [5:0] code);
		logic [6:0] c;
		begin
			case (code)
				6'h02: c = 7'h21;
				6'h03: c = 7'h40;
				6'h04: c = 7'h23;
				6'h05: c = 7'h24;
				6'h06: c = 7'h25;
				6'h07: c = 7'h5E;
				6'h08: c = 7'h26;
				6'h09: c = 7'h2A;
				6'h0A: c = 7'h28;
				6'h0B: c = 7'h29;
				6'h0C: c = 7'h5F;
				6'h0D: c = 7'h2B;
				6'h0E: c = 7'h08;
				6'h0F: c = 7'h09;
				6'h10: c = 7'h51;
				6'h11: c = 7'h57;
				6'h12: c = 7'h45;
				6'h13: c = 7'h52;
				6'h14: c = 7'h54;
				6'h15: c = 7'h59;
				6'h16: c = 7'h55;
				6'h17: c = 7'h49;
				6'h18: c = 7'h4F;
				6'h19: c = 7'h50;
				6'h1A: c = 7'h7B;
				6'h1B: c = 7'h7D;
				6'h1C: c = 7'h0A;
				6'h1E: c = 7'h41;
				6'h1F: c = 7'h53;
				6'h20: c = 7'h44;
				6'h21: c = 7'h46;
				6'h22: c = 7'h47;
				6'h23: c = 7'h48;
				6'h24: c = 7'h4A;
				6'h25: c = 7'h4B;
				6'h26: c = 7'h4C;
				6'h27: c = 7'h3A;
				6'h28: c = 7'h22;
				6'h29: c = 7'h7E;
				6'h2B: c = 7'h7C;
				6'h2C: c = 7'h5A;
				6'h2D: c = 7'h58;
				6'h2E: c = 7'h43;
				6'h2F: c = 7'h56;
				6'h30: c = 7'h42;
				6'h31: c = 7'h4E;
				6'h32: c = 7'h4D;
				6'h33: c = 7'h3C;
				6'h34: c = 7'h3E;
				6'h35: c = 7'h3F;
				6'h37: c = 7'h2A;
				6'h39: c = 7'h20;
				default: c = 7'h00;
			endcase
			return c;
		end
	endfunction

	function automatic logic [6:0] control_char(input logic [6:0] base);
		logic [6:0] s;
		begin
			s = base;
			if (s >= 7'h61 && s <= 7'h7A) begin
				s = s - ASCII_CASE;
			end
			if (s == 7'h2D) begin
				s = 7'h5F;
			end
			if (s == 7'h60) begin
				s = 7'h40;
			end
			if (s >= ASCII_CTRL && s <= ASCII_CTRL_HI) begin
				return s - ASCII_CTRL;
			end
			return base;
		end
	endfunction

endpackage

FILE: rtl/scancode_set1_to_ascii_decoder.sv
// ----------------------------------------------------------------------------
// scancode_set1_to_ascii_decoder
// Turns keyboard scan code set 1 bytes into US layout ASCII characters,
// tracking the extended prefix, control and shift.
// ----------------------------------------------------------------------------
//  channel   signals                          item
//  in        in_valid, in_stall, scan_byte    one raw scan byte
//  out       out_valid, out_stall, char_code  one ASCII character, 0 or 1 per byte
//
//  A byte is registered on entry and decoded from that register; its
//  character (if any) is loaded into the output register when the output is free.
//  One byte is accepted every cycle while the output is not stalled.
//  A stalled output holds its character; the input stalls only when a byte
//  is waiting behind it. Reset clears the prefix, control and shift flags.
// ----------------------------------------------------------------------------
module scancode_set1_to_ascii_decoder
	import sc1asc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] scan_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] char_code
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	flags_t     flags_q;
	logic       out_valid_q;
	logic [6:0] char_q;
	logic       out_free;
	logic       adv;
	dec_t       dec;

	assign out_free  = !out_valid_q || !out_stall;
	assign adv       = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign out_valid = out_valid_q;
	assign char_code = char_q;

	sc1asc_decode u_decode (
		.scan_byte (byte_s1),
		.flags     (flags_q),
		.dec       (dec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			flags_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				flags_q <= dec.flags;
			end
			if (out_free) begin
				out_valid_q <= adv && dec.emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= scan_byte;
		end
		if (out_free && adv && dec.emit) begin
			char_q <= dec.chr;
		end
	end

`ifndef ASSERT_OFF
	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid && out_stall))
		else $error("input stalled without a blocked output");

	a_prefix_swallows: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && flags_q.prefix) |=> (!out_valid && !flags_q.prefix))
		else $error("byte after prefix produced a character or kept the prefix");

	a_flags_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(flags_q))
		else $error("modifier flags changed without a decoded byte");
`endif

endmodule

FILE: rtl/sc1asc_decode.sv
// ----------------------------------------------------------------------------
// sc1asc_decode
// Decodes one scan byte against the current modifier flags into an optional
// character and the next flag values.
// ----------------------------------------------------------------------------
module sc1asc_decode
	import sc1asc_pkg::*;
(
	input  logic [7:0] scan_byte,
	input  flags_t     flags,
	output dec_t       dec
);

	logic [6:0] code;
	logic       down;
	logic [6:0] base;
	logic [6:0] shifted;

	assign code    = scan_byte[6:0];
	assign down    = (scan_byte & SC_RELEASE) == 8'h00;
	assign base    = plain_char(code[5:0]);
	assign shifted = shift_char(code[5:0]);

	always_comb begin
		dec.emit  = 1'b0;
		dec.chr   = 7'h00;
		dec.flags = flags;
		if (flags.prefix) begin
			dec.flags.prefix = 1'b0;
		end else if (scan_byte == SC_PREFIX) begin
			dec.flags.prefix = 1'b1;
		end else if (code == SC_CTRL) begin
			dec.flags.ctrl = down;
		end else if (code == SC_LSHIFT || code == SC_RSHIFT) begin
			dec.flags.shift = down;
		end else if (!down) begin
			dec.emit = 1'b0;
		end else if (code == SC_ESC) begin
			dec.emit = 1'b1;
			dec.chr  = ASCII_ESC;
		end else if (code < NUM_MAIN_KEYS && base != 7'h00) begin
			dec.emit = 1'b1;
			if (flags.ctrl) begin
				dec.chr = control_char(base);
			end else if (flags.shift) begin
				dec.chr = shifted;
			end else begin
				dec.chr = base;
			end
		end
	end

endmodule

FILE: bench/sc1asc_checker.sv
// ----------------------------------------------------------------------------
// sc1asc_checker
// Watches both channels of the set 1 decoder, tracks the prefix, control and
// shift flags on its own, queues the character each accepted scan byte should
// produce and compares every accepted output character against the oldest one.
// ----------------------------------------------------------------------------
module sc1asc_checker
	import sc1asc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] scan_byte,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [6:0] char_code,
	output int         fail_count,
	output int         chars_waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [8*58-1:0] PLAIN_KEYS = {
		8'h00, 8'h00, "1234567890-=", 8'h08, 8'h09, "qwertyuiop[]", 8'h0A,
		8'h00, "asdfghjkl;", 8'h27, 8'h60, 8'h00, 8'h5C, "zxcvbnm,./",
		8'h00, "*", 8'h00, " "
	};
	localparam logic [8*58-1:0] SHIFT_KEYS = {
		8'h00, 8'h00, "!@#$%^&*()_+", 8'h08, 8'h09, "QWERTYUIOP{}", 8'h0A,
		8'h00, "ASDFGHJKL:", 8'h22, "~", 8'h00, "|", "ZXCVBNM<>?",
		8'h00, "*", 8'h00, " "
	};

	logic       prefix_seen;
	logic       ctrl_down;
	logic       shift_down;
	logic [6:0] char_queue [$];

	initial begin
		fail_count = 0;
		chars_waiting = 0;
	end

	function automatic logic [6:0] ctrl_code(input logic [6:0] base);
		logic [6:0] s;
		s = base;
		if (s >= 7'h61 && s <= 7'h7A) begin
			s = s - 7'h20;
		end
		if (s == 7'h2D) begin
			s = 7'h5F;
		end
		if (s == 7'h60) begin
			s = 7'h40;
		end
		if (s >= 7'h40 && s <= 7'h5F) begin
			return s - 7'h40;
		end
		return base;
	endfunction

	task automatic predict_char(input logic [7:0] b);
		logic [6:0] key;
		logic       pressed;
		logic [6:0] plain;
		logic [6:0] shifted;
		key = b[6:0];
		pressed = !b[7];
		if (prefix_seen) begin
			prefix_seen = 1'b0;
		end else if (b == SC_PREFIX) begin
			prefix_seen = 1'b1;
		end else if (key == SC_CTRL) begin
			ctrl_down = pressed;
		end else if (key == SC_LSHIFT || key == SC_RSHIFT) begin
			shift_down = pressed;
		end else if (pressed && key == SC_ESC) begin
			char_queue.push_back(ASCII_ESC);
		end else if (pressed && key < NUM_MAIN_KEYS) begin
			plain = PLAIN_KEYS[8 * (57 - key) +: 7];
			shifted = SHIFT_KEYS[8 * (57 - key) +: 7];
			if (plain != 7'h00) begin
				if (ctrl_down) begin
					char_queue.push_back(ctrl_code(plain));
				end else if (shift_down) begin
					char_queue.push_back(shifted);
				end else begin
					char_queue.push_back(plain);
				end
			end
		end
	endtask

	function automatic void note_failure(input string what, input logic [6:0] want,
			input logic [6:0] got);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t: %s: expected 0x%02h, got 0x%02h", $realtime, what, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [6:0] want;
		if (!arst_n) begin
			prefix_seen = 1'b0;
			ctrl_down = 1'b0;
			shift_down = 1'b0;
			char_queue.delete();
			chars_waiting = 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_char(scan_byte);
			end
			if (out_valid && !out_stall) begin
				if (char_queue.size() == 0) begin
					note_failure("character with none expected", 7'h00, char_code);
				end else begin
					want = char_queue.pop_front();
					if (char_code !== want) begin
						note_failure("char_code mismatch", want, char_code);
					end
				end
			end
			chars_waiting = char_queue.size();
		end
	end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the set 1 scan code decoder. Drives directed and random scan
// byte streams with random sender gaps and receiver stalls, one long output
// hold-off and drain pauses; the checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module tb_top
	import sc1asc_pkg::*;
;
	timeunit 1ns;
	timeprecision 1ps;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] scan_byte;
	logic       out_valid;
	logic       out_stall;
	logic [6:0] char_code;
	int         fail_count;
	int         chars_waiting;
	int         send_pct;
	int         recv_pct;
	logic       hold_request;

	scancode_set1_to_ascii_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.scan_byte (scan_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_code (char_code)
	);

	sc1asc_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.scan_byte     (scan_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.char_code     (char_code),
		.fail_count    (fail_count),
		.chars_waiting (chars_waiting)
	);

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		scan_byte = 8'h00;
		out_stall = 1'b0;
		send_pct = 15;
		recv_pct = 72;
		hold_request = 1'b0;
	end

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				for (int i = 0; i < 300; i++) begin
					out_stall <= 1'b1;
					@(negedge clk);
				end
			end
			out_stall <= ($urandom_range(99) < recv_pct);
		end
	end

	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		scan_byte <= b;
		do begin
			@(posedge clk);
		end while (in_stall);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (chars_waiting != 0) begin
			@(negedge clk);
		end
	endtask

	function automatic logic [7:0] random_scan();
		int r;
		r = $urandom_range(99);
		if (r < 40) begin
			return 8'($urandom_range(8'h39, 8'h02));
		end else if (r < 55) begin
			return SC_RELEASE | 8'($urandom_range(8'h7F));
		end else if (r < 70) begin
			case ($urandom_range(2))
				0: return {$urandom_range(1) == 1, SC_CTRL};
				1: return {$urandom_range(1) == 1, SC_LSHIFT};
				default: return {$urandom_range(1) == 1, SC_RSHIFT};
			endcase
		end else if (r < 78) begin
			return SC_PREFIX;
		end else if (r < 83) begin
			return {1'b0, SC_ESC};
		end
		return 8'($urandom_range(255));
	endfunction

	task automatic run_random(input int count, input int hold_at, input int pause_at);
		for (int i = 0; i < count; i++) begin
			if (i == hold_at) begin
				hold_request = 1'b1;
			end
			if (i == pause_at) begin
				wait_drained();
			end
			send_byte(random_scan());
		end
	endtask

	initial begin
		logic [7:0] directed [$];
		directed = '{8'h00, 8'hFF, 8'h01, 8'h1E, 8'h39, 8'h2A, 8'h02, 8'h36, 8'hAA,
			8'h1D, 8'h1E, 8'h0C, 8'h29, 8'h02, 8'h01, 8'hE0, 8'h9D, 8'hE0, 8'hE0,
			8'h1E, 8'h9D, 8'h3A, 8'h7F, 8'h38, 8'h57, 8'h9E};
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			send_byte(directed[i]);
		end
		run_random(250, 100, 180);
		wait_drained();

		send_pct = 72;
		recv_pct = 15;
		run_random(250, -1, 120);
		wait_drained();

		send_pct = 0;
		recv_pct = 0;
		run_random(250, -1, -1);
		wait_drained();
		repeat (10) @(negedge clk);

		if (fail_count == 0 && chars_waiting == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/sc1asc_pkg.sv
rtl/sc1asc_decode.sv
rtl/scancode_set1_to_ascii_decoder.sv
bench/sc1asc_checker.sv
bench/tb_top.sv
